>>> sv/acczt_pkg.sv
// Shared types, constants and a helper function for the accelerometer auto-zero trim block.
package acczt_pkg;

  localparam int SampleBits  = 12;
  localparam int TrimBits    = 8;
  localparam int WinBits     = 8;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = SampleBits;
  localparam int NumAxes     = 3;

  localparam logic [SampleBits-1:0] SampleMax   = {SampleBits{1'b1}};
  localparam logic [SampleBits-1:0] MidReset    = SampleBits'(1 << (SampleBits - 1));
  localparam logic [TrimBits-1:0]   TrimStartRst = TrimBits'(160);
  localparam logic [TrimBits-1:0]   TrimLowRst   = '0;
  localparam logic [TrimBits-1:0]   TrimHighRst  = {TrimBits{1'b1}};
  localparam logic [SampleBits-1:0] ZeroTolRst   = SampleBits'(5);
  localparam logic [SampleBits-1:0] SpreadRst    = SampleBits'(4);
  localparam logic [WinBits-1:0]    WinLenRst    = WinBits'(40);

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhTrim   = 2'd1,
    PhSettle = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgEnableTrim   = 3'd0,
    CfgTrimStart    = 3'd1,
    CfgTrimLow      = 3'd2,
    CfgTrimHigh     = 3'd3,
    CfgMidpoint     = 3'd4,
    CfgZeroTol      = 3'd5,
    CfgSpreadLimit  = 3'd6,
    CfgWindowLength = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                  enable_trim;
    logic [TrimBits-1:0]   trim_start;
    logic [TrimBits-1:0]   trim_low;
    logic [TrimBits-1:0]   trim_high;
    logic [SampleBits-1:0] midpoint;
    logic [SampleBits-1:0] zero_tolerance;
    logic [SampleBits-1:0] spread_limit;
    logic [WinBits-1:0]    window_length;
  } cfg_t;

  typedef struct packed {
    logic                  action;
    logic [SampleBits-1:0] sample_x;
    logic [SampleBits-1:0] sample_y;
    logic [SampleBits-1:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [TrimBits-1:0]   pwm_trim_x;
    logic [TrimBits-1:0]   pwm_trim_y;
    logic [SampleBits-1:0] center_x;
    logic [SampleBits-1:0] center_y;
    logic [SampleBits-1:0] center_z;
    logic [SampleBits-1:0] zero_x;
    logic [SampleBits-1:0] zero_y;
  } out_item_t;

  typedef struct packed {
    logic                finished;
    logic [TrimBits-1:0] trim;
  } axis_res_t;

  // One trim check on one axis: finish when close enough or pinned at a limit,
  // otherwise step the trim down if the sample is below the midpoint, else up.
  function automatic axis_res_t trim_axis(input logic [SampleBits-1:0] s,
                                          input logic [TrimBits-1:0]   trim,
                                          input cfg_t                  cfg);
    logic [SampleBits-1:0] distance;
    axis_res_t             res;
    distance = (s >= cfg.midpoint) ? s - cfg.midpoint : cfg.midpoint - s;
    res.finished = 1'b0;
    res.trim     = trim;
    if (distance <= cfg.zero_tolerance) begin
      res.finished = 1'b1;
    end else if (s < cfg.midpoint) begin
      if (trim <= cfg.trim_low) begin
        res.finished = 1'b1;
      end else begin
        res.trim = trim - TrimBits'(1);
      end
    end else begin
      if (trim >= cfg.trim_high) begin
        res.finished = 1'b1;
      end else begin
        res.trim = trim + TrimBits'(1);
      end
    end
    return res;
  endfunction

endpackage

>>> sv/acczt_chan_if.sv
// Valid/ready channel interface carrying one item of a chosen payload type.
interface acczt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/acczt_cfg.sv
// Configuration register file with reset values and indexed write port.
module acczt_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [acczt_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [acczt_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  output acczt_pkg::cfg_t                    cfg_o
);
  import acczt_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgEnableTrim:   cfg_d.enable_trim    = cfg_wdata_i[0];
        CfgTrimStart:    cfg_d.trim_start     = cfg_wdata_i[TrimBits-1:0];
        CfgTrimLow:      cfg_d.trim_low       = cfg_wdata_i[TrimBits-1:0];
        CfgTrimHigh:     cfg_d.trim_high      = cfg_wdata_i[TrimBits-1:0];
        CfgMidpoint:     cfg_d.midpoint       = cfg_wdata_i[SampleBits-1:0];
        CfgZeroTol:      cfg_d.zero_tolerance = cfg_wdata_i[SampleBits-1:0];
        CfgSpreadLimit:  cfg_d.spread_limit   = cfg_wdata_i[SampleBits-1:0];
        CfgWindowLength: cfg_d.window_length  = cfg_wdata_i[WinBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_trim    <= 1'b1;
      cfg_q.trim_start     <= TrimStartRst;
      cfg_q.trim_low       <= TrimLowRst;
      cfg_q.trim_high      <= TrimHighRst;
      cfg_q.midpoint       <= MidReset;
      cfg_q.zero_tolerance <= ZeroTolRst;
      cfg_q.spread_limit   <= SpreadRst;
      cfg_q.window_length  <= WinLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

>>> sv/acczt_core.sv
// Calibration state and the single-pass next-state logic that forms each result.
module acczt_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_en_i,
  input  acczt_pkg::in_item_t   item_i,
  input  acczt_pkg::cfg_t       cfg_i,
  output acczt_pkg::out_item_t  result_o
);
  import acczt_pkg::*;

  phase_e                phase_q, phase_d;
  logic                  skip_q, skip_d;
  logic [TrimBits-1:0]   trim_x_q, trim_x_d, trim_y_q, trim_y_d;
  logic                  xfin_q, xfin_d, yfin_q, yfin_d;
  logic [WinBits-1:0]    wcnt_q, wcnt_d;
  logic [SampleBits-1:0] amin_q [NumAxes];
  logic [SampleBits-1:0] amin_d [NumAxes];
  logic [SampleBits-1:0] amax_q [NumAxes];
  logic [SampleBits-1:0] amax_d [NumAxes];
  logic [SampleBits-1:0] zero_x_q, zero_x_d, zero_y_q, zero_y_d;

  logic [SampleBits-1:0] smp [NumAxes];
  logic [WinBits-1:0]    win_len;
  logic [WinBits-1:0]    wcnt_inc;
  logic [SampleBits-1:0] center [NumAxes];
  logic [SampleBits:0]   csum [NumAxes];
  axis_res_t             res_x, res_y;

  assign smp[0]  = item_i.sample_x;
  assign smp[1]  = item_i.sample_y;
  assign smp[2]  = item_i.sample_z;
  assign win_len = (cfg_i.window_length == '0) ? WinBits'(1) : cfg_i.window_length;
  assign wcnt_inc = wcnt_q + WinBits'(1);
  assign res_x   = trim_axis(item_i.sample_x, trim_x_q, cfg_i);
  assign res_y   = trim_axis(item_i.sample_y, trim_y_q, cfg_i);

  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    trim_x_d = trim_x_q;
    trim_y_d = trim_y_q;
    xfin_d   = xfin_q;
    yfin_d   = yfin_q;
    wcnt_d   = wcnt_q;
    zero_x_d = zero_x_q;
    zero_y_d = zero_y_q;
    for (int i = 0; i < NumAxes; i++) begin
      amin_d[i] = amin_q[i];
      amax_d[i] = amax_q[i];
    end
    if (step_en_i) begin
      if (item_i.action) begin
        trim_x_d = cfg_i.trim_start;
        trim_y_d = cfg_i.trim_start;
        xfin_d   = 1'b0;
        yfin_d   = 1'b0;
        skip_d   = 1'b1;
        wcnt_d   = '0;
        for (int i = 0; i < NumAxes; i++) begin
          amin_d[i] = SampleMax;
          amax_d[i] = '0;
        end
        zero_x_d = cfg_i.midpoint;
        zero_y_d = cfg_i.midpoint;
        phase_d  = cfg_i.enable_trim ? PhTrim : PhSettle;
      end else begin
        case (phase_q)
          PhTrim: begin
            if (skip_q) begin
              skip_d = 1'b0;
            end else begin
              skip_d = 1'b1;
              if (!xfin_q) begin
                xfin_d   = res_x.finished;
                trim_x_d = res_x.trim;
                zero_x_d = item_i.sample_x;
              end
              if (!yfin_q) begin
                yfin_d   = res_y.finished;
                trim_y_d = res_y.trim;
                zero_y_d = item_i.sample_y;
              end
              if (xfin_d && yfin_d) begin
                wcnt_d = '0;
                for (int i = 0; i < NumAxes; i++) begin
                  amin_d[i] = SampleMax;
                  amax_d[i] = '0;
                end
                phase_d = PhSettle;
              end
            end
          end
          PhSettle: begin
            for (int i = 0; i < NumAxes; i++) begin
              amin_d[i] = (smp[i] < amin_q[i]) ? smp[i] : amin_q[i];
              amax_d[i] = (smp[i] > amax_q[i]) ? smp[i] : amax_q[i];
            end
            wcnt_d = wcnt_inc;
            if (wcnt_inc >= win_len) begin
              if ((amax_d[0] - amin_d[0] > cfg_i.spread_limit) ||
                  (amax_d[1] - amin_d[1] > cfg_i.spread_limit)) begin
                wcnt_d = '0;
                for (int i = 0; i < NumAxes; i++) begin
                  amin_d[i] = SampleMax;
                  amax_d[i] = '0;
                end
              end else begin
                phase_d  = PhDone;
                zero_x_d = item_i.sample_x;
                zero_y_d = item_i.sample_y;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      csum[i]   = {1'b0, amin_d[i]} + {1'b0, amax_d[i]};
      center[i] = (phase_d == PhDone) ? csum[i][SampleBits:1] : '0;
    end
  end

  assign result_o.status     = phase_d;
  assign result_o.pwm_trim_x = trim_x_d;
  assign result_o.pwm_trim_y = trim_y_d;
  assign result_o.center_x   = center[0];
  assign result_o.center_y   = center[1];
  assign result_o.center_z   = center[2];
  assign result_o.zero_x     = zero_x_d;
  assign result_o.zero_y     = zero_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      skip_q   <= 1'b1;
      trim_x_q <= TrimStartRst;
      trim_y_q <= TrimStartRst;
      xfin_q   <= 1'b0;
      yfin_q   <= 1'b0;
      wcnt_q   <= '0;
      zero_x_q <= MidReset;
      zero_y_q <= MidReset;
      for (int i = 0; i < NumAxes; i++) begin
        amin_q[i] <= SampleMax;
        amax_q[i] <= '0;
      end
    end else begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      trim_x_q <= trim_x_d;
      trim_y_q <= trim_y_d;
      xfin_q   <= xfin_d;
      yfin_q   <= yfin_d;
      wcnt_q   <= wcnt_d;
      zero_x_q <= zero_x_d;
      zero_y_q <= zero_y_d;
      for (int i = 0; i < NumAxes; i++) begin
        amin_q[i] <= amin_d[i];
        amax_q[i] <= amax_d[i];
      end
    end
  end
endmodule

>>> sv/accel_autozero_trim_settle.sv
// Top level of the accelerometer offset auto-zero trim and settling detector.
// An accepted item passes through the input register and then the result register,
// which it enters once the result register is free or being drained.
// Throughput: one item per cycle while results drain, set by the core's state update.
// Reset: control state and configuration return to their defaults; the block is idle.
module accel_autozero_trim_settle (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  acczt_chan_if.sink                         in_chan,
  acczt_chan_if.source                       out_chan,
  input  logic                               cfg_we_i,
  input  logic [acczt_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [acczt_pkg::CfgDataBits-1:0]  cfg_wdata_i
);
  import acczt_pkg::*;

  // Input register. It holds one accepted item until the result register has room.
  logic      in_valid_q;
  in_item_t  in_item_q;
  // Result register. It holds one finished result until the sink takes it.
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      advance;
  logic      step_en;
  cfg_t      cfg;
  out_item_t result;

  // The held item moves into the result register whenever that register is
  // empty or is being drained this cycle. The input register in turn takes a
  // new item whenever it is empty or its item moves on, so a steady stream
  // runs at one item per cycle and a stall on the result side only backs up
  // once both registers are full.
  assign advance       = !out_valid_q || out_chan.ready;
  assign step_en       = in_valid_q && advance;
  assign in_chan.ready = !in_valid_q || advance;

  acczt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The core updates the calibration state exactly once per item, at the edge
  // where that item moves into the result register, and hands over the result
  // that the updated state gives.
  acczt_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_q <= in_chan.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_item_q <= result;
    end
  end

  assign out_chan.valid   = out_valid_q;
  assign out_chan.payload = out_item_q;

  // An item that moves on always shows up as a result in the next cycle.
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> out_valid_q)
    else $error("item processed but no result registered");

  // Centers are only reported once settled.
  a_centers_only_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.status != PhDone)) |->
      (out_item_q.center_x == '0 && out_item_q.center_y == '0 &&
       out_item_q.center_z == '0))
    else $error("nonzero center reported outside settled phase");

  // Once a run has started the block never falls back to idle.
  a_no_return_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.status != PhIdle)) |=> (out_item_q.status != PhIdle))
    else $error("status returned to idle after a run started");

endmodule
